@@ sv/pp_pkg.sv @@
// ----------------------------------------------------------------------------
// pp_pkg: shared types for the polygon perimeter block
// Sequencer states and the control and status bundles of the square root unit.
// ----------------------------------------------------------------------------
package pp_pkg;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SQX    = 7'b0000010,
    ST_SQY    = 7'b0000100,
    ST_RSTART = 7'b0001000,
    ST_RWAIT  = 7'b0010000,
    ST_ADD    = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  typedef struct packed {
    logic start;
  } sqrt_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

@@ sv/pp_in_if.sv @@
// ----------------------------------------------------------------------------
// pp_in_if: vertex input channel
// Valid/ready channel carrying one polygon vertex per item.
// ----------------------------------------------------------------------------
interface pp_in_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic                          last_vertex;

  modport source (output valid, output x_coord, output y_coord, output last_vertex,
                  input ready);
  modport sink   (input valid, input x_coord, input y_coord, input last_vertex,
                  output ready);
endinterface

@@ sv/pp_out_if.sv @@
// ----------------------------------------------------------------------------
// pp_out_if: perimeter result channel
// Valid/ready channel carrying one perimeter result per item.
// ----------------------------------------------------------------------------
interface pp_out_if #(
  parameter int SUM_WIDTH = 48
) ();
  logic                 valid;
  logic                 ready;
  logic [SUM_WIDTH-1:0] perimeter;
  logic                 saturated;

  modport source (output valid, output perimeter, output saturated, input ready);
  modport sink   (input valid, input perimeter, input saturated, output ready);
endinterface

@@ sv/polygon_perimeter_core.sv @@
// ----------------------------------------------------------------------------
// polygon_perimeter_core: polygon perimeter accumulator
// Sums floor-rounded fixed point edge lengths over a stream of vertices.
// ----------------------------------------------------------------------------
// Vertices enter one item at a time; the vertex flagged last closes the
// polygon and one perimeter item is produced (the closing edge back to the
// first vertex is counted only for three or more vertices). The first vertex
// of a polygon is stored without an edge. Every other vertex runs through the
// accept state, squaring dx and then dy on the shared multiplier for the
// squared deltas, a load state, ROOT_W steps of the
// one-bit-per-cycle square root unit, a wait for its done flag and an add. A last
// vertex with a closing edge repeats that sequence without the accept state,
// and any last vertex then loads the result register, which may wait there
// while the downstream side stalls. The input is not ready while an edge is
// in progress.
// ----------------------------------------------------------------------------
module polygon_perimeter_core #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8,
  parameter int SUM_WIDTH   = 48
) (
  input  logic       clk,
  input  logic       rst,
  pp_in_if.sink      in_ch,
  pp_out_if.source   out_ch
);

  localparam int SQ_W      = 2 * COORD_WIDTH + 1;
  localparam int RAD_RAW_W = SQ_W + 2 * FRAC_BITS;
  localparam int RAD_W     = RAD_RAW_W + (RAD_RAW_W % 2);
  localparam int ROOT_W    = RAD_W / 2;
  localparam int EXT_W     = ((SUM_WIDTH > ROOT_W) ? SUM_WIDTH : ROOT_W) + 1;

  pp_pkg::state_t state;

  logic signed [COORD_WIDTH-1:0] first_x, first_y;
  logic signed [COORD_WIDTH-1:0] previous_x, previous_y;
  logic signed [COORD_WIDTH-1:0] edge_ax, edge_ay, edge_bx, edge_by;
  logic                          cur_last;
  logic                          closing;
  logic [1:0]                    vertex_count;
  logic [SUM_WIDTH-1:0]          running_sum;
  logic                          sum_overflowed;
  logic [SQ_W-1:0]               sq_acc;

  logic                          out_valid;
  logic [SUM_WIDTH-1:0]          out_perimeter;
  logic                          out_saturated;

  logic signed [COORD_WIDTH:0]   diff_x, diff_y;
  logic [COORD_WIDTH-1:0]        mag_x, mag_y, mul_op;
  logic [2*COORD_WIDTH-1:0]      prod;
  logic [RAD_W-1:0]              radicand;
  logic [ROOT_W-1:0]             root;
  logic [EXT_W-1:0]              sum_ext;
  logic                          sum_over;
  logic                          accept;
  logic                          out_free;

  pp_pkg::sqrt_ctrl_t sq_ctrl;
  pp_pkg::sqrt_stat_t sq_stat;

  assign diff_x = {edge_ax[COORD_WIDTH-1], edge_ax} - {edge_bx[COORD_WIDTH-1], edge_bx};
  assign diff_y = {edge_ay[COORD_WIDTH-1], edge_ay} - {edge_by[COORD_WIDTH-1], edge_by};
  assign mag_x  = diff_x[COORD_WIDTH] ? COORD_WIDTH'(-diff_x) : diff_x[COORD_WIDTH-1:0];
  assign mag_y  = diff_y[COORD_WIDTH] ? COORD_WIDTH'(-diff_y) : diff_y[COORD_WIDTH-1:0];

  // One multiplier squares dx, then dy on the following cycle.
  assign mul_op = (state == pp_pkg::ST_SQX) ? mag_x : mag_y;
  assign prod   = mul_op * mul_op;

  assign radicand = RAD_W'(sq_acc) << (2 * FRAC_BITS);
  assign sq_ctrl.start = (state == pp_pkg::ST_RSTART);

  pp_isqrt #(
    .RAD_W  (RAD_W),
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (sq_ctrl),
    .radicand (radicand),
    .stat     (sq_stat),
    .root     (root)
  );

  assign sum_ext  = EXT_W'(running_sum) + EXT_W'(root);
  assign sum_over = |sum_ext[EXT_W-1:SUM_WIDTH];

  assign in_ch.ready = (state == pp_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pp_pkg::ST_IDLE;
      vertex_count   <= 2'd0;
      running_sum    <= '0;
      sum_overflowed <= 1'b0;
      closing        <= 1'b0;
      cur_last       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (state == pp_pkg::ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        pp_pkg::ST_IDLE: begin
          if (accept) begin
            cur_last <= in_ch.last_vertex;
            closing  <= 1'b0;
            if (vertex_count != 2'd3) begin
              vertex_count <= vertex_count + 2'd1;
            end
            if (vertex_count == 2'd0) begin
              state <= in_ch.last_vertex ? pp_pkg::ST_FINISH : pp_pkg::ST_IDLE;
            end else begin
              state <= pp_pkg::ST_SQX;
            end
          end
        end
        pp_pkg::ST_SQX:    state <= pp_pkg::ST_SQY;
        pp_pkg::ST_SQY:    state <= pp_pkg::ST_RSTART;
        pp_pkg::ST_RSTART: state <= pp_pkg::ST_RWAIT;
        pp_pkg::ST_RWAIT: begin
          if (sq_stat.done) begin
            state <= pp_pkg::ST_ADD;
          end
        end
        pp_pkg::ST_ADD: begin
          if (sum_over) begin
            running_sum    <= '1;
            sum_overflowed <= 1'b1;
          end else begin
            running_sum <= sum_ext[SUM_WIDTH-1:0];
          end
          if (cur_last && !closing && vertex_count == 2'd3) begin
            closing <= 1'b1;
            state   <= pp_pkg::ST_SQX;
          end else if (cur_last) begin
            state <= pp_pkg::ST_FINISH;
          end else begin
            state <= pp_pkg::ST_IDLE;
          end
        end
        pp_pkg::ST_FINISH: begin
          if (out_free) begin
            vertex_count   <= 2'd0;
            running_sum    <= '0;
            sum_overflowed <= 1'b0;
            state          <= pp_pkg::ST_IDLE;
          end
        end
        default: state <= pp_pkg::ST_IDLE;
      endcase
    end
  end

  // Datapath registers; these carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      edge_ax    <= in_ch.x_coord;
      edge_ay    <= in_ch.y_coord;
      edge_bx    <= previous_x;
      edge_by    <= previous_y;
      previous_x <= in_ch.x_coord;
      previous_y <= in_ch.y_coord;
      if (vertex_count == 2'd0) begin
        first_x <= in_ch.x_coord;
        first_y <= in_ch.y_coord;
      end
    end
    // The closing edge runs from the last vertex back to the first one.
    if (state == pp_pkg::ST_ADD && cur_last && !closing) begin
      edge_bx <= first_x;
      edge_by <= first_y;
    end
    if (state == pp_pkg::ST_SQX) begin
      sq_acc <= SQ_W'(prod);
    end
    if (state == pp_pkg::ST_SQY) begin
      sq_acc <= sq_acc + SQ_W'(prod);
    end
    if (state == pp_pkg::ST_FINISH && out_free) begin
      out_perimeter <= running_sum;
      out_saturated <= sum_overflowed;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.perimeter = out_perimeter;
  assign out_ch.saturated = out_saturated;

`ifndef SYNTHESIS
  a_ready_not_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !sq_stat.busy)
    else $error("input ready while the square root unit is busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_stat.done |-> (state == pp_pkg::ST_RWAIT))
    else $error("square root finished outside the wait state");

  a_sat_all_ones: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.saturated) |-> (&out_ch.perimeter))
    else $error("saturated perimeter is not all ones");

  a_edge_has_vertex: assert property (@(posedge clk) disable iff (rst)
    (state == pp_pkg::ST_SQX) |-> (vertex_count != 2'd0))
    else $error("edge started with no previous vertex");
`endif

endmodule

@@ sv/pp_isqrt.sv @@
// ----------------------------------------------------------------------------
// pp_isqrt: iterative integer square root
// Restoring bit-pair square root, one root bit per cycle, floor result.
// ----------------------------------------------------------------------------
module pp_isqrt #(
  parameter int RAD_W  = 50,
  parameter int ROOT_W = RAD_W / 2
) (
  input  logic                clk,
  input  logic                rst,
  input  pp_pkg::sqrt_ctrl_t  ctrl,
  input  logic [RAD_W-1:0]    radicand,
  output pp_pkg::sqrt_stat_t  stat,
  output logic [ROOT_W-1:0]   root
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // The remainder never exceeds twice the partial root, so its top two bits
  // are free to drop when the next pair is shifted in.
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
